### rtl/core/imu_dfr_pkg.sv
// shared types and constants for the imu serial frame deframer
package imu_dfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned TypeW      = 2;
  localparam int unsigned FrameLen   = 11;
  localparam int unsigned StoreDepth = 9;
  localparam int unsigned CountW     = 4;
  localparam int unsigned OutDataW   = ((TypeW + 4 * WordW + 7) / 8) * 8;

  localparam logic [ByteW-1:0] HdrByte   = 8'h55;
  localparam logic [ByteW-1:0] TypeAcc   = 8'h51;
  localparam logic [ByteW-1:0] TypeGyro  = 8'h52;
  localparam logic [ByteW-1:0] TypeAngle = 8'h53;

  typedef enum logic [TypeW-1:0] {
    FRAME_ACC   = 2'd0,
    FRAME_GYRO  = 2'd1,
    FRAME_ANGLE = 2'd2
  } frame_type_e;

  typedef struct packed {
    logic signed [WordW-1:0] word_extra;
    logic signed [WordW-1:0] word_z;
    logic signed [WordW-1:0] word_y;
    logic signed [WordW-1:0] word_x;
    frame_type_e             frame_type;
  } result_t;

endpackage

### rtl/core/imu_dfr_collect.sv
// input byte register, frame byte store and frame decode
module imu_dfr_collect (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [imu_dfr_pkg::ByteW-1:0]  in_byte_i,
  input  logic                           res_ready_i,
  output logic                           res_valid_o,
  output imu_dfr_pkg::result_t           res_o
);

  logic                                  byte_valid_q;
  logic [imu_dfr_pkg::ByteW-1:0]         byte_q;
  logic [imu_dfr_pkg::CountW-1:0]        count_q, count_d;
  logic [imu_dfr_pkg::ByteW-1:0]         store_q [imu_dfr_pkg::StoreDepth];
  logic                                  advance;
  logic                                  frame_end;
  logic                                  type_known;

  assign advance    = byte_valid_q && res_ready_i;
  assign in_ready_o = !byte_valid_q || res_ready_i;
  assign frame_end  = count_q >= imu_dfr_pkg::CountW'(imu_dfr_pkg::FrameLen - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (count_q == '0) begin
      if (byte_q == imu_dfr_pkg::HdrByte) begin
        count_d = imu_dfr_pkg::CountW'(1);
      end
    end else if (frame_end) begin
      count_d = '0;
    end else begin
      count_d = count_q + imu_dfr_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance) begin
      count_q <= count_d;
    end
  end

  // frame bytes 1 to 9 land in slots 0 to 8
  for (genvar i = 0; i < imu_dfr_pkg::StoreDepth; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (advance && count_q == imu_dfr_pkg::CountW'(i + 1)) begin
        store_q[i] <= byte_q;
      end
    end
  end

  always_comb begin
    type_known       = 1'b1;
    res_o.frame_type = imu_dfr_pkg::FRAME_ACC;
    case (store_q[0])
      imu_dfr_pkg::TypeAcc:   res_o.frame_type = imu_dfr_pkg::FRAME_ACC;
      imu_dfr_pkg::TypeGyro:  res_o.frame_type = imu_dfr_pkg::FRAME_GYRO;
      imu_dfr_pkg::TypeAngle: res_o.frame_type = imu_dfr_pkg::FRAME_ANGLE;
      default:                type_known       = 1'b0;
    endcase
    res_o.word_x     = {store_q[2], store_q[1]};
    res_o.word_y     = {store_q[4], store_q[3]};
    res_o.word_z     = {store_q[6], store_q[5]};
    res_o.word_extra = {store_q[8], store_q[7]};
  end

  assign res_valid_o = advance && frame_end && type_known;

endmodule

### rtl/core/imu_dfr_outbuf.sv
// result register with skid stage
module imu_dfr_outbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  output logic                  res_ready_o,
  input  imu_dfr_pkg::result_t  res_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output imu_dfr_pkg::result_t  out_o
);

  logic                  main_valid_q;
  logic                  skid_valid_q;
  imu_dfr_pkg::result_t  main_q;
  imu_dfr_pkg::result_t  skid_q;
  logic                  main_load;

  assign res_ready_o = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;
  assign main_load   = !main_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_load) begin
      main_valid_q <= skid_valid_q || res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_load) begin
      main_q <= skid_valid_q ? skid_q : res_i;
    end else if (res_valid_i && !skid_valid_q) begin
      skid_q <= res_i;
    end
  end

endmodule

### rtl/core/imu_serial_frame_deframer_top.sv
// top level of the imu serial frame deframer
// Takes one serial byte per transaction and rebuilds eleven-byte sensor frames
// that open with header 0x55; bytes outside a frame are dropped, byte 1 is the
// type (0x51 accel, 0x52 angular rate, 0x53 angle), bytes 2 to 9 are four
// little-endian signed words and the checksum byte is not checked. A frame of
// known type yields one transaction on the master side when its last byte is
// taken; unknown types yield nothing. One byte is accepted every cycle unless the
// output backs up: a byte register feeds the frame logic and a result register
// with a skid stage decouples the output.
module imu_serial_frame_deframer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [imu_dfr_pkg::ByteW-1:0]       s_axis_tdata,  // rx_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // frame_type, word_x, word_y, word_z, word_extra, zero pad
  output logic [imu_dfr_pkg::OutDataW-1:0]    m_axis_tdata
);

  logic                  res_valid;
  logic                  res_ready;
  imu_dfr_pkg::result_t  res;
  imu_dfr_pkg::result_t  out;

  imu_dfr_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  imu_dfr_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = imu_dfr_pkg::OutDataW'(out);

endmodule

### sim/imu_dfr_checker.sv
// scoreboard for the imu serial frame deframer: predicts decoded frames and checks the output
module imu_dfr_checker
  import imu_dfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [ByteW-1:0]    s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  err_count_o,
  output int                  pending_o,
  output int                  decoded_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResW = $bits(result_t);

  logic [CountW-1:0] frame_pos = '0;
  logic [ByteW-1:0]  frame_buf [StoreDepth];
  result_t           decoded_q [$];
  int                err_count = 0;
  int                pending   = 0;
  int                decoded   = 0;

  assign err_count_o = err_count;
  assign pending_o   = pending;
  assign decoded_o   = decoded;

  // advance the frame state by one byte, returns 1 when a frame is decoded
  function automatic logic absorb_byte(input logic [ByteW-1:0] rx, output result_t res);
    res = '0;
    if (frame_pos == '0) begin
      if (rx == HdrByte) frame_pos = CountW'(1);
      return 1'b0;
    end
    if (frame_pos < CountW'(FrameLen - 1)) begin
      frame_buf[frame_pos - CountW'(1)] = rx;
      frame_pos = frame_pos + CountW'(1);
      return 1'b0;
    end
    frame_pos = '0;
    case (frame_buf[0])
      TypeAcc:   res.frame_type = FRAME_ACC;
      TypeGyro:  res.frame_type = FRAME_GYRO;
      TypeAngle: res.frame_type = FRAME_ANGLE;
      default:   return 1'b0;
    endcase
    res.word_x     = {frame_buf[2], frame_buf[1]};
    res.word_y     = {frame_buf[4], frame_buf[3]};
    res.word_z     = {frame_buf[6], frame_buf[5]};
    res.word_extra = {frame_buf[8], frame_buf[7]};
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        seen = result_t'(m_tdata_i[ResW-1:0]);
        decoded++;
        if (decoded_q.size() == 0) begin
          $error("result transaction with nothing expected: tdata %h", m_tdata_i);
          err_count++;
        end else begin
          want = decoded_q.pop_front();
          if (seen.frame_type !== want.frame_type) begin
            $error("frame_type expected %0d actual %0d", want.frame_type, seen.frame_type);
            err_count++;
          end
          if (seen.word_x !== want.word_x) begin
            $error("word_x expected %0d actual %0d", want.word_x, seen.word_x);
            err_count++;
          end
          if (seen.word_y !== want.word_y) begin
            $error("word_y expected %0d actual %0d", want.word_y, seen.word_y);
            err_count++;
          end
          if (seen.word_z !== want.word_z) begin
            $error("word_z expected %0d actual %0d", want.word_z, seen.word_z);
            err_count++;
          end
          if (seen.word_extra !== want.word_extra) begin
            $error("word_extra expected %0d actual %0d", want.word_extra, seen.word_extra);
            err_count++;
          end
        end
        if (m_tdata_i[OutDataW-1:ResW] !== '0) begin
          $error("tdata pad expected 0 actual %h", m_tdata_i[OutDataW-1:ResW]);
          err_count++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (absorb_byte(s_tdata_i, want)) decoded_q.push_back(want);
      end
      pending <= decoded_q.size();
    end
  end

endmodule

### sim/tb.sv
// testbench top for the imu serial frame deframer: byte stimulus, output stalls and verdict
module tb;
  import imu_dfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteTarget = 1600;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned TailCycles = 16;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata  = '0;   // rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;       // frame_type, word_x, word_y, word_z, word_extra, pad

  int err_count;
  int pending;
  int decoded;
  int frame_bytes_sent = 0;
  int bytes_sent       = 0;
  int idle_cycles      = 0;
  bit tx_idle_en       = 1'b1;
  bit rx_idle_en       = 1'b1;
  bit hold_req         = 1'b0;

  imu_serial_frame_deframer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  imu_dfr_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .err_count_o (err_count),
    .pending_o   (pending),
    .decoded_o   (decoded)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: random stall per transaction, one long hold on request
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      gap = rx_idle_en ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] rx);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // header, type code, four little-endian words, checksum
  task automatic send_frame(input logic [ByteW-1:0] type_code, input logic [4*WordW-1:0] words,
                            input logic [ByteW-1:0] chk);
    send_byte(HdrByte);
    send_byte(type_code);
    for (int i = 0; i < 8; i++) send_byte(words[8*i +: 8]);
    send_byte(chk);
    frame_bytes_sent += FrameLen;
  endtask

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return WordW'($urandom);
    endcase
  endfunction

  function automatic logic [4*WordW-1:0] pick_words();
    return {pick_word(), pick_word(), pick_word(), pick_word()};
  endfunction

  function automatic logic [ByteW-1:0] pick_type();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return TypeAcc;
    if (r < 6) return TypeGyro;
    if (r < 9) return TypeAngle;
    return ByteW'($urandom);
  endfunction

  initial begin
    int  phase_left;
    int  cut;
    bit  hold_done;
    phase_left = 0;
    hold_done  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray bytes, word extremes with header bytes inside the frame, unknown type
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(TypeAcc, {16'hFFFF, 16'h5555, 16'h7FFF, 16'h8000}, HdrByte);
    send_frame(8'h54, {16'h1234, 16'h8000, 16'h7FFF, 16'hA5A5}, 8'h00);

    while (frame_bytes_sent < ByteTarget) begin
      if (phase_left == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
        phase_left = $urandom_range(5, 20);
      end
      phase_left--;
      if (!hold_done && frame_bytes_sent >= ByteTarget / 2) begin
        // long output stall while frames keep coming, so the input backs up
        hold_done  = 1'b1;
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (10) send_frame(pick_type(), pick_words(), ByteW'($urandom));
      end
      case ($urandom_range(0, 7))
        0: repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom));
        1: begin
          // truncated frame, the following bytes are taken as its data
          cut = $urandom_range(1, 9);
          send_byte(HdrByte);
          repeat (cut) send_byte(ByteW'($urandom));
          frame_bytes_sent += cut + 1;
        end
        default: send_frame(pick_type(), pick_words(), ByteW'($urandom));
      endcase
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d serial bytes sent, %0d decoded frames compared", bytes_sent, decoded);
    $display("covered all frame types, unknown types, stray and truncated input, long output hold");
    if (err_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### imu_serial_frame_deframer_top.f
rtl/core/imu_dfr_pkg.sv
rtl/core/imu_dfr_collect.sv
rtl/core/imu_dfr_outbuf.sv
rtl/core/imu_serial_frame_deframer_top.sv
sim/imu_dfr_checker.sv
sim/tb.sv
